[src/trial_division_prime_filter_macros.svh]
// Assertion macros shared by the prime filter sources.
// Each assertion is sampled on clk and is switched off while rst_n is low.
`ifndef TRIAL_DIVISION_PRIME_FILTER_MACROS_SVH
`define TRIAL_DIVISION_PRIME_FILTER_MACROS_SVH

`ifndef SYNTHESIS

`define TDPF_ASSERT_SAME(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed")

`define TDPF_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed")

`else

`define TDPF_ASSERT_SAME(lbl, cond, cons)

`define TDPF_ASSERT_NEXT(lbl, cond, cons)

`endif

`endif

[src/tdpf_pkg.sv]
`timescale 1ns / 1ps

package tdpf_pkg;

    // Status of one finished trial division, read by the sequencer.
    typedef struct packed {
        logic done;       // one-cycle pulse when the division has finished
        logic exact;      // remainder is zero
        logic past_root;  // quotient is below the divisor, so divisor squared exceeds n
    } div_stat_t;

endpackage

[src/tdpf_divider.sv]
`timescale 1ns / 1ps
`include "trial_division_prime_filter_macros.svh"

module tdpf_divider #(
    parameter int N = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [N-1:0]      dividend,
    input  logic [N-1:0]      divisor,
    output logic              busy,
    output tdpf_pkg::div_stat_t stat
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  rem_reg;
    logic [N-1:0]  quo_reg;
    logic [N-1:0]  div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [N:0]    trial;
    logic [N+1:0]  diff;
    logic          take;

    // Restoring division, one quotient bit a cycle. The dividend shifts out of the
    // top of quo_reg while quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};
    assign take  = ~diff[N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                cnt_reg  <= CW'(N);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    rem_reg <= diff[N-1:0];
                end
                else
                begin
                    rem_reg <= trial[N-1:0];
                end
                quo_reg <= {quo_reg[N-2:0], take};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy           = busy_reg;
    assign stat.done      = done_reg;
    assign stat.exact     = (rem_reg == '0);
    assign stat.past_root = (quo_reg < div_reg);

    `TDPF_ASSERT_SAME(a_no_start_when_busy, start, !busy_reg);
    `TDPF_ASSERT_NEXT(a_done_single_pulse, done_reg, !done_reg);
    `TDPF_ASSERT_SAME(a_count_live_when_busy, busy_reg, cnt_reg != '0);

endmodule

[src/tdpf_ctrl.sv]
`timescale 1ns / 1ps

module tdpf_ctrl #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cand_valid,
    input  logic [W-1:0]        candidate,
    output logic                cand_stall,
    output logic                div_start,
    output logic [W-2:0]        dividend,
    output logic [W-2:0]        divisor,
    input  tdpf_pkg::div_stat_t div_stat,
    output logic                res_valid,
    output logic [W-2:0]        res_value,
    input  logic                res_ready
);

    localparam int N = W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    logic [N-1:0] n_reg;
    logic [N-1:0] n_next;
    logic [N-1:0] d_reg;
    logic [N-1:0] d_next;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Negative values, zero and one are dropped straight away.
                if (cand_valid && !candidate[W-1] && (candidate[N-1:0] > N'(1)))
                begin
                    n_next     = candidate[N-1:0];
                    d_next     = N'(2);
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.past_root)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (div_stat.exact)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + N'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            d_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            d_reg     <= d_next;
        end
    end

    assign cand_stall = (state_reg != ST_IDLE);
    assign div_start  = (state_reg == ST_START);
    assign dividend   = n_reg;
    assign divisor    = d_reg;
    assign res_valid  = (state_reg == ST_EMIT);
    assign res_value  = n_reg;

endmodule

[src/trial_division_prime_filter.sv]
`timescale 1ns / 1ps
`include "trial_division_prime_filter_macros.svh"

// Channel      Valid         Stall         Word
// input        cand_valid    cand_stall    candidate   (VALUE_WIDTH bits, signed)
// output       prime_valid   prime_stall   prime_value (VALUE_WIDTH-1 bits)
//
// Each trial divisor takes one pass of the bit-serial divider, and a value n
// takes about floor(sqrt(n)) - 1 divisors. Negative values, zero and one are
// dropped without any division.
// Reset clears the sequencer and the output register; there is no clearing pass.
// A waiting prime is held in the output register while a new word is taken in.

module trial_division_prime_filter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cand_valid,
    output logic                   cand_stall,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output logic                   prime_valid,
    input  logic                   prime_stall,
    output logic [VALUE_WIDTH-2:0] prime_value
);

    localparam int N = VALUE_WIDTH - 1;

    logic                div_start;
    logic                div_busy;
    logic [N-1:0]        dividend;
    logic [N-1:0]        divisor;
    tdpf_pkg::div_stat_t div_stat;
    logic                res_valid;
    logic [N-1:0]        res_value;
    logic                res_ready;

    logic                out_valid_reg;
    logic [N-1:0]        out_value_reg;

    tdpf_ctrl #(
        .W (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .candidate  (candidate),
        .cand_stall (cand_stall),
        .div_start  (div_start),
        .dividend   (dividend),
        .divisor    (divisor),
        .div_stat   (div_stat),
        .res_valid  (res_valid),
        .res_value  (res_value),
        .res_ready  (res_ready)
    );

    tdpf_divider #(
        .N (N)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .stat     (div_stat)
    );

    // The output register takes a new word once its current one has gone.
    assign res_ready = !out_valid_reg || !prime_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_value_reg <= res_value;
            end
        end
    end

    assign prime_valid = out_valid_reg;
    assign prime_value = out_value_reg;

    `TDPF_ASSERT_SAME(a_prime_at_least_two, prime_valid, prime_value > N'(1));
    `TDPF_ASSERT_NEXT(a_accepted_value_starts_work,
        cand_valid && !cand_stall && !candidate[VALUE_WIDTH-1] && (candidate[N-1:0] > N'(1)),
        cand_stall);
    `TDPF_ASSERT_SAME(a_prime_follows_work, $rose(prime_valid), $past(cand_stall));
    `TDPF_ASSERT_SAME(a_divider_idle_when_free, !cand_stall, !div_busy);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int WIDTH = 32;
    // The largest positive word is prime, so it runs the most trial divisions.
    localparam longint CYCLE_LIMIT = 8_000_000;
    localparam int DRAIN_CYCLES = 20000;

    logic             clk;
    logic             rst_n;
    logic             cand_valid;
    logic             cand_stall;
    logic [WIDTH-1:0] candidate;
    logic             prime_valid;
    logic             prime_stall;
    logic [WIDTH-2:0] prime_value;

    logic [WIDTH-2:0] primes_due[$];
    int               fault_count = 0;
    int               primes_seen = 0;
    longint           cycle_count = 0;
    int               hold_left = 0;
    bit               calm = 1'b0;

    trial_division_prime_filter #(
        .VALUE_WIDTH(WIDTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .candidate  (candidate),
        .prime_valid(prime_valid),
        .prime_stall(prime_stall),
        .prime_value(prime_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic bit is_prime_number(longint unsigned n);
        longint unsigned d;
        if (n <= 1)
            return 1'b0;
        // Testing d <= n / d keeps d * d from overflowing.
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Mostly small values, so that each word needs few trial divisors.
    // Large positive words are kept even, which the first trial divisor of 2 rejects.
    function automatic logic [WIDTH-1:0] pick_candidate();
        int               r;
        logic [WIDTH-1:0] w;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 45)
            w = 2 * $urandom_range(0, 150) + 1;
        else if (r < 60)
            w = $urandom_range(0, 300);
        else if (r < 80)
            w = $urandom_range(0, 20000);
        else if (r < 90)
            w[WIDTH-1] = 1'b1;
        else
            w = {1'b0, w[WIDTH-2:1], 1'b0};
        return w;
    endfunction

    task automatic send_word(input logic [WIDTH-1:0] word);
        @(negedge clk);
        cand_valid <= 1'b1;
        candidate  <= word;
        @(posedge clk);
        while (cand_stall)
            @(posedge clk);
        if (!word[WIDTH-1] && is_prime_number({32'b0, word}))
            primes_due.push_back(word[WIDTH-2:0]);
    endtask

    task automatic sender_pause();
        int n;
        n = calm ? 0 : pick_gap();
        if (n > 0)
        begin
            @(negedge clk);
            cand_valid <= 1'b0;
            candidate  <= $urandom;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_for_primes();
        @(negedge clk);
        cand_valid <= 1'b0;
        while (primes_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int run;
        bit stalling;
        prime_stall = 1'b0;
        run = 0;
        stalling = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                prime_stall <= 1'b1;
                hold_left--;
            end
            else if (calm)
                prime_stall <= 1'b0;
            else
            begin
                if (run == 0)
                begin
                    stalling = !stalling;
                    run = stalling ? pick_gap() : $urandom_range(1, 10);
                    if (run == 0)
                    begin
                        stalling = 1'b0;
                        run = $urandom_range(1, 10);
                    end
                end
                prime_stall <= stalling;
                run--;
            end
        end
    end

    always @(posedge clk)
    begin : check_prime
        logic [WIDTH-2:0] due;
        if (rst_n && prime_valid && !prime_stall)
        begin
            if (primes_due.size() == 0)
            begin
                fault_count++;
                $display("%0t: prime_value expected none, got %0d", $time, prime_value);
            end
            else
            begin
                due = primes_due.pop_front();
                primes_seen++;
                if (prime_value !== due)
                begin
                    fault_count++;
                    $display("%0t: prime_value expected %0d, got %0d", $time, due, prime_value);
                end
            end
        end
    end

    task automatic test_field_extremes();
        logic [WIDTH-1:0] words[9];
        words = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4,
                  32'h7FFF_FFFE, 32'h7FFF_FFFF};
        foreach (words[i])
        begin
            send_word(words[i]);
            sender_pause();
        end
    endtask

    // Squares of primes sit exactly on the divisor limit; other primes and composites are sent too.
    task automatic test_square_boundaries();
        logic [WIDTH-1:0] words[7];
        words = '{32'd9, 32'd25, 32'd121, 32'd15, 32'd97, 32'd65537, 32'd65535};
        foreach (words[i])
        begin
            send_word(words[i]);
            sender_pause();
        end
    endtask

    // The receiver holds off while primes keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        logic [WIDTH-1:0] words[6];
        words = '{32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd19};
        wait_for_primes();
        calm = 1'b1;
        hold_left = 3000;
        foreach (words[i])
            send_word(words[i]);
        wait_for_primes();
        calm = 1'b0;
    endtask

    task automatic test_random_words();
        int n;
        n = 0;
        while (n < 100)
        begin
            if (n % 25 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_word(pick_candidate());
            sender_pause();
            n++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cand_valid = 1'b0;
        candidate = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_square_boundaries();
        test_output_backpressure();
        test_random_words();

        wait_for_primes();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_count == 0 && primes_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
